// ===== rtl/arc_pkg.sv =====
// Shared types and constants for the ARP reply learning cache.
// Holds status codes, header constants and the controller/datapath structs.
// No dependencies.
package arc_pkg;

  localparam int unsigned EtypeW = 16;
  localparam int unsigned OpW    = 16;
  localparam int unsigned IpW    = 32;
  localparam int unsigned MacW   = 48;

  localparam logic [EtypeW-1:0] EthertypeArp = 16'h0806;
  localparam logic [OpW-1:0]    OpRequest    = 16'd1;
  localparam logic [OpW-1:0]    OpReply      = 16'd2;

  typedef enum logic {
    FUNC_LEARN  = 1'b0,
    FUNC_LOOKUP = 1'b1
  } func_e;

  typedef enum logic [2:0] {
    ST_LEARNED = 3'd0,
    ST_NOT_ARP = 3'd1,
    ST_REQUEST = 3'd2,
    ST_BAD_OP  = 3'd3,
    ST_FULL    = 3'd4,
    ST_HIT     = 3'd5,
    ST_MISS    = 3'd6
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;    // capture the input item, restart the scan index
    logic    rd;      // read the entry at the scan index
    logic    adv;     // advance the scan index
    logic    emit;    // load the output register
    logic    wr;      // write the item into the table
    logic    wr_new;  // write at the fill count and grow it
    status_e status;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_lookup;
    logic not_arp;
    logic is_request;
    logic is_reply;
    logic scan_end;
    logic match;
    logic full;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/arc_ctrl.sv =====
// Controller of the ARP reply learning cache: sequences decode, table scan
// and result hand-off. Depends on arc_pkg.
module arc_ctrl import arc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DECODE = 5'b00010,
    S_READ   = 5'b00100,
    S_CMP    = 5'b01000,
    S_DONE   = 5'b10000
  } state_e;

  state_e  state_q, state_d;
  status_e res_status_q, res_status_d;
  logic    res_wr_q, res_wr_d;
  logic    res_wr_new_q, res_wr_new_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d      = state_q;
    res_status_d = res_status_q;
    res_wr_d     = res_wr_q;
    res_wr_new_d = res_wr_new_q;
    cmd_o        = '0;
    cmd_o.status = res_status_q;
    cmd_o.wr_new = res_wr_new_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts_i.is_lookup || (!sts_i.not_arp && sts_i.is_reply)) begin
          state_d = S_READ;
        end else begin
          res_wr_d     = 1'b0;
          res_wr_new_d = 1'b0;
          if (sts_i.not_arp) begin
            res_status_d = ST_NOT_ARP;
          end else if (sts_i.is_request) begin
            res_status_d = ST_REQUEST;
          end else begin
            res_status_d = ST_BAD_OP;
          end
          state_d = S_DONE;
        end
      end
      S_READ: begin
        if (sts_i.scan_end) begin
          // key absent: a lookup misses, a reply takes the next free entry if the table is not full
          res_wr_new_d = 1'b1;
          if (sts_i.is_lookup) begin
            res_status_d = ST_MISS;
            res_wr_d     = 1'b0;
          end else if (sts_i.full) begin
            res_status_d = ST_FULL;
            res_wr_d     = 1'b0;
          end else begin
            res_status_d = ST_LEARNED;
            res_wr_d     = 1'b1;
          end
          state_d = S_DONE;
        end else begin
          cmd_o.rd = 1'b1;
          state_d  = S_CMP;
        end
      end
      S_CMP: begin
        if (sts_i.match) begin
          res_status_d = sts_i.is_lookup ? ST_HIT : ST_LEARNED;
          res_wr_d     = !sts_i.is_lookup;
          res_wr_new_d = 1'b0;
          state_d      = S_DONE;
        end else begin
          cmd_o.adv = 1'b1;
          state_d   = S_READ;
        end
      end
      S_DONE: begin
        // hold until the output register can take the transaction
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.wr   = res_wr_q;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      res_status_q <= ST_LEARNED;
      res_wr_q     <= 1'b0;
      res_wr_new_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      res_status_q <= res_status_d;
      res_wr_q     <= res_wr_d;
      res_wr_new_q <= res_wr_new_d;
    end
  end

endmodule

// ===== rtl/arc_dpath.sv =====
// Datapath of the ARP reply learning cache: item register, entry memory,
// scan index, fill count and output register. Depends on arc_pkg.
module arc_dpath import arc_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              func_i,
  input  logic [EtypeW-1:0] eth_type_i,
  input  logic [OpW-1:0]    arp_op_i,
  input  logic [IpW-1:0]    sender_ip_i,
  input  logic [MacW-1:0]   sender_mac_i,
  input  logic [IpW-1:0]    lookup_ip_i,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [2:0]        status_o,
  output logic              hit_o,
  output logic [MacW-1:0]   mac_out_o
);

  localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CW-1:0] FullCount = CW'(TABLE_ENTRIES);

  logic              func_q;
  logic [EtypeW-1:0] etype_q;
  logic [OpW-1:0]    op_q;
  logic [IpW-1:0]    sip_q;
  logic [MacW-1:0]   smac_q;
  logic [IpW-1:0]    lip_q;

  logic [CW-1:0]     idx_q, idx_d;
  logic [CW-1:0]     fill_q, fill_d;
  logic [IpW-1:0]    rd_ip_q;
  logic [MacW-1:0]   rd_mac_q;

  logic [IpW+MacW-1:0] tbl_mem [TABLE_ENTRIES];

  logic              out_valid_q;
  status_e           out_status_q;
  logic              out_hit_q;
  logic [MacW-1:0]   out_mac_q;

  logic [IpW-1:0]    key;
  logic [AW-1:0]     wr_addr;
  logic              res_hit;

  assign key     = (func_q == FUNC_LOOKUP) ? lip_q : sip_q;
  assign wr_addr = cmd_i.wr_new ? fill_q[AW-1:0] : idx_q[AW-1:0];
  assign res_hit = (cmd_i.status == ST_HIT);

  always_comb begin
    sts_o.is_lookup  = (func_q == FUNC_LOOKUP);
    sts_o.not_arp    = (etype_q != EthertypeArp);
    sts_o.is_request = (op_q == OpRequest);
    sts_o.is_reply   = (op_q == OpReply);
    sts_o.scan_end   = (idx_q == fill_q);
    sts_o.match      = (rd_ip_q == key);
    sts_o.full       = (fill_q == FullCount);
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

  // item capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q  <= func_i;
      etype_q <= eth_type_i;
      op_q    <= arp_op_i;
      sip_q   <= sender_ip_i;
      smac_q  <= sender_mac_i;
      lip_q   <= lookup_ip_i;
    end
  end

  // entries fill from index zero and are never freed, so the fill count
  // stands in for the valid bits
  always_comb begin
    idx_d  = idx_q;
    fill_d = fill_q;
    if (cmd_i.load) begin
      idx_d = '0;
    end else if (cmd_i.adv) begin
      idx_d = idx_q + CW'(1);
    end
    if (cmd_i.wr && cmd_i.wr_new) begin
      fill_d = fill_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      fill_q <= '0;
    end else begin
      idx_q  <= idx_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      tbl_mem[wr_addr] <= {smac_q, sip_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      {rd_mac_q, rd_ip_q} <= tbl_mem[idx_q[AW-1:0]];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_status_q <= cmd_i.status;
      out_hit_q    <= res_hit;
      out_mac_q    <= res_hit ? rd_mac_q : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign hit_o       = out_hit_q;
  assign mac_out_o   = out_mac_q;

endmodule

// ===== rtl/arp_reply_learning_cache.sv =====
// Top level of the ARP reply learning cache: IPv4-to-MAC table learned from
// ARP replies, with lookups. Depends on arc_pkg, arc_ctrl and arc_dpath.
//
//   channel  dir  width  contents
//   s_axis   in   144+1  learn header or lookup address, tuser selects
//   m_axis   out  48+4   stored MAC, status and hit flag
//
// A non-reply learn passes from IDLE through DECODE to DONE. A scan reads
// the entry memory one entry per READ/CMP pass, alternating those states,
// and goes to DONE on a match or, with no match, once the scan index
// reaches the fill count.
// Reset clears the fill count; no clearing pass runs over the memory.
// A stalled output holds in its register while the next item is accepted.
module arp_reply_learning_cache import arc_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // eth_type[15:0], arp_op[31:16], sender_ip[63:32], sender_mac[111:64],
  // lookup_ip[143:112]
  input  logic [143:0] s_axis_tdata_i,
  // func[0]
  input  logic         s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // mac_out[47:0]
  output logic [47:0]  m_axis_tdata_o,
  // status[2:0], hit[3]
  output logic [3:0]   m_axis_tuser_o
);

  cmd_t       cmd;
  sts_t       sts;
  logic [2:0] status;
  logic       hit;

  arc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  arc_dpath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .func_i       (s_axis_tuser_i),
    .eth_type_i   (s_axis_tdata_i[15:0]),
    .arp_op_i     (s_axis_tdata_i[31:16]),
    .sender_ip_i  (s_axis_tdata_i[63:32]),
    .sender_mac_i (s_axis_tdata_i[111:64]),
    .lookup_ip_i  (s_axis_tdata_i[143:112]),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .status_o     (status),
    .hit_o        (hit),
    .mac_out_o    (m_axis_tdata_o)
  );

  assign m_axis_tuser_o = {hit, status};

`ifndef SYNTHESIS
  a_wr_with_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.wr |-> cmd.emit)
    else $error("table written without a result transaction");

  a_no_append_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.wr && cmd.wr_new && sts.full))
    else $error("new entry appended to a full table");

  a_mac_zero_on_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !hit) |-> (m_axis_tdata_o == '0))
    else $error("non-zero MAC on a result without hit");
`endif

endmodule
